/* rtl/core/scharr_gradient_magnitude_direction_assert.svh */
// Assertion macros used by the checker file.
`ifndef SCHARR_GRADIENT_MAGNITUDE_DIRECTION_ASSERT_SVH
`define SCHARR_GRADIENT_MAGNITUDE_DIRECTION_ASSERT_SVH
`define SGMD_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SGMD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`endif

/* rtl/core/sgmd_pkg.sv */
// Package with widths, constants and the arctangent table of the Scharr block.
package sgmd_pkg;
  localparam int unsigned MaxWidth = 2048;
  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned AngleFracBits = 12;
  localparam int unsigned CordicSteps = 14;
  localparam int unsigned CordicW = 32;
  localparam int unsigned ZW = 34;
  localparam logic signed [ZW-1:0] PiQ30 = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_NONE         = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MAG,
    BK_ITER,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    logic [7:0] w00, w01, w02;
    logic [7:0] w10, w11, w12;
    logic [7:0] w20, w21, w22;
    logic       last;
  } win_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 34'sd843314856;
      1: v = 34'sd497837829;
      2: v = 34'sd263043836;
      3: v = 34'sd133525158;
      4: v = 34'sd67021686;
      5: v = 34'sd33543515;
      6: v = 34'sd16775850;
      7: v = 34'sd8388437;
      8: v = 34'sd4194282;
      9: v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

/* rtl/core/sgmd_front.sv */
// Front end: line stores, 3x3 window and frame sequencing.
module sgmd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [15:0]               cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      cmd_i,
  input  logic [7:0]                pixel_i,
  output logic                      in_ready_o,
  output logic                      win_valid_o,
  output sgmd_pkg::win_t            win_o,
  input  logic                      win_ready_i
);
  logic [sgmd_pkg::ColW-1:0] col_q, col_d, drn_q, drn_d;
  logic [15:0] row_q, row_d;
  logic [11:0] fw_q;
  logic [15:0] fh_q;
  logic [sgmd_pkg::ColW:0] w_eff;
  logic [16:0] h_eff;
  logic [7:0] upper_mem [sgmd_pkg::MaxWidth];
  logic [7:0] lower_mem [sgmd_pkg::MaxWidth];

  // Stage 1: accepted item, memory read in flight.
  logic s1_v_q, s1_drain_q, s1_r1_q, s1_r2_q, s1_first_q, s1_c1_q, s1_end_q;
  logic [7:0] s1_p_q, up_rd_q, lo_rd_q;
  logic [sgmd_pkg::ColW-1:0] s1_addr_q;
  logic [7:0] wc1_q [3];
  logic [7:0] wc2_q [3];
  logic [1:0] pend_q;
  sgmd_pkg::win_t wa_q, wb_q;
  logic [1:0] emit_n;
  sgmd_pkg::win_t ea, eb;

  logic drain, act, take, cfg_hit;
  logic [sgmd_pkg::ColW-1:0] c;
  logic [sgmd_pkg::ColW:0] cn;
  logic [7:0] top, mid;

  always_comb begin
    w_eff = (fw_q < 12'd3) ? (sgmd_pkg::ColW+1)'(3) :
            ({1'b0, fw_q} > 13'(sgmd_pkg::MaxWidth)) ? (sgmd_pkg::ColW+1)'(sgmd_pkg::MaxWidth) :
            (sgmd_pkg::ColW+1)'(fw_q);
    h_eff = (fh_q < 16'd2) ? 17'd2 : {1'b0, fh_q};
  end

  assign in_ready_o = (pend_q == 2'd0) && !s1_v_q;
  assign take = in_valid_i && in_ready_o;
  assign drain = (cmd_i == sgmd_pkg::CMD_DRAIN);
  assign act = take && (drain ? ({1'b0, row_q} >= h_eff) : ({1'b0, row_q} < h_eff));
  assign cfg_hit = cfg_we_i && (cfg_idx_i == sgmd_pkg::REG_FRAME_WIDTH ||
                                cfg_idx_i == sgmd_pkg::REG_FRAME_HEIGHT);

  always_comb begin
    c = drain ? drn_q : col_q;
    if ({1'b0, c} >= w_eff) c = '0;
    cn = {1'b0, c} + 1'b1;
    col_d = col_q;
    drn_d = drn_q;
    row_d = row_q;
    if (drain) begin
      if (cn >= w_eff) begin
        col_d = '0; drn_d = '0; row_d = '0;
      end else begin
        drn_d = cn[sgmd_pkg::ColW-1:0];
      end
    end else if (cn >= w_eff) begin
      col_d = '0;
      row_d = row_q + 16'd1;
    end else begin
      col_d = cn[sgmd_pkg::ColW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (act) begin
      up_rd_q <= upper_mem[c];
      lo_rd_q <= lower_mem[c];
    end
    if (s1_v_q && !s1_drain_q) begin
      upper_mem[s1_addr_q] <= mid;
      lower_mem[s1_addr_q] <= s1_p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act) begin
      s1_addr_q <= c;
      s1_p_q <= drain ? 8'd0 : pixel_i;
      s1_drain_q <= drain;
      s1_r1_q <= row_q >= 16'd1;
      s1_r2_q <= row_q >= 16'd2;
      s1_first_q <= c != '0;
      s1_c1_q <= c == (sgmd_pkg::ColW)'(1);
      s1_end_q <= ({1'b0, c} == w_eff - 1'b1);
    end
  end

  assign mid = s1_r1_q ? lo_rd_q : 8'd0;
  assign top = s1_r2_q ? up_rd_q : 8'd0;

  always_comb begin
    ea = '0;
    eb = '0;
    ea.w00 = s1_c1_q ? 8'd0 : wc1_q[0];
    ea.w10 = s1_c1_q ? 8'd0 : wc1_q[1];
    ea.w20 = s1_c1_q ? 8'd0 : wc1_q[2];
    ea.w01 = wc2_q[0]; ea.w11 = wc2_q[1]; ea.w21 = wc2_q[2];
    ea.w02 = top; ea.w12 = mid; ea.w22 = s1_p_q;
    eb.w00 = wc2_q[0]; eb.w10 = wc2_q[1]; eb.w20 = wc2_q[2];
    eb.w01 = top; eb.w11 = mid; eb.w21 = s1_p_q;
    eb.last = s1_drain_q;
    emit_n = 2'((s1_r1_q && s1_first_q) ? 1 : 0) + 2'((s1_r1_q && s1_end_q) ? 1 : 0);
  end

  assign win_valid_o = pend_q != 2'd0;
  assign win_o = wa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; drn_q <= '0; row_q <= '0;
      fw_q <= 12'd640; fh_q <= 16'd480;
      s1_v_q <= 1'b0; pend_q <= 2'd0;
      for (int k = 0; k < 3; k++) begin
        wc1_q[k] <= '0; wc2_q[k] <= '0;
      end
    end else begin
      s1_v_q <= act;
      if (cfg_hit) begin
        col_q <= '0; drn_q <= '0; row_q <= '0;
        for (int k = 0; k < 3; k++) begin
          wc1_q[k] <= '0; wc2_q[k] <= '0;
        end
      end else begin
        if (act) begin
          col_q <= col_d; drn_q <= drn_d; row_q <= row_d;
        end
        if (s1_v_q) begin
          wc1_q[0] <= wc2_q[0]; wc1_q[1] <= wc2_q[1]; wc1_q[2] <= wc2_q[2];
          wc2_q[0] <= top; wc2_q[1] <= mid; wc2_q[2] <= s1_p_q;
        end
      end
      if (s1_v_q) begin
        if (emit_n == 2'd2) begin
          wa_q <= ea; wb_q <= eb;
        end else if (s1_first_q) begin
          wa_q <= ea;
        end else begin
          wa_q <= eb;
        end
        pend_q <= emit_n;
      end else if (win_valid_o && win_ready_i) begin
        wa_q <= wb_q;
        pend_q <= pend_q - 2'd1;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == sgmd_pkg::REG_FRAME_WIDTH) fw_q <= cfg_data_i[11:0];
        if (cfg_idx_i == sgmd_pkg::REG_FRAME_HEIGHT) fh_q <= cfg_data_i;
      end
    end
  end
endmodule

/* rtl/core/sgmd_back.sv */
// Back end: gradients, squared magnitude and a sequential CORDIC direction.
module sgmd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  win_valid_i,
  input  sgmd_pkg::win_t        win_i,
  output logic                  win_ready_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [24:0]           mag_o,
  output logic signed [14:0]    dir_o,
  output logic signed [12:0]    gx_o,
  output logic signed [12:0]    gy_o,
  output logic                  last_o
);
  sgmd_pkg::bk_state_e st_q, st_d;
  logic signed [12:0] gx_q, gy_q;
  logic [24:0] mag_q;
  logic last_q;
  logic signed [sgmd_pkg::CordicW-1:0] x_q, y_q;
  logic signed [sgmd_pkg::ZW-1:0] z_q;
  logic [4:0] i_q;
  logic signed [14:0] dir_sat;
  logic signed [12:0] gx, gy;
  logic signed [sgmd_pkg::ZW-1:0] zr, m;
  logic [sgmd_pkg::ZW-1:0] r;
  logic signed [sgmd_pkg::ZW-1:0] rs;

  function automatic logic signed [12:0] px(input logic [7:0] p);
    return $signed({5'b0, p});
  endfunction

  always_comb begin
    gx = 13'sd3 * (px(win_i.w02) - px(win_i.w00)) + 13'sd10 * (px(win_i.w12) - px(win_i.w10))
       + 13'sd3 * (px(win_i.w22) - px(win_i.w20));
    gy = 13'sd3 * (px(win_i.w20) + px(win_i.w22)) + 13'sd10 * px(win_i.w21)
       - 13'sd3 * (px(win_i.w00) + px(win_i.w02)) - 13'sd10 * px(win_i.w01);
  end

  assign win_ready_o = st_q == sgmd_pkg::BK_IDLE;
  assign res_valid_o = st_q == sgmd_pkg::BK_DONE;

  logic signed [sgmd_pkg::CordicW-1:0] dx, dy;
  always_comb begin
    dx = x_q >>> i_q;
    dy = y_q >>> i_q;
    st_d = st_q;
    case (st_q)
      sgmd_pkg::BK_IDLE: if (win_valid_i) st_d = sgmd_pkg::BK_MAG;
      sgmd_pkg::BK_MAG: st_d = (gx_q == 0 || gy_q == 0) ? sgmd_pkg::BK_DONE : sgmd_pkg::BK_ITER;
      sgmd_pkg::BK_ITER: if (i_q == 5'(sgmd_pkg::CordicSteps - 1)) st_d = sgmd_pkg::BK_DONE;
      sgmd_pkg::BK_DONE: if (res_ready_i) st_d = sgmd_pkg::BK_IDLE;
      default: st_d = sgmd_pkg::BK_IDLE;
    endcase
    zr = z_q;
    if (zr > sgmd_pkg::PiQ30) zr = sgmd_pkg::PiQ30;
    if (zr < -sgmd_pkg::PiQ30) zr = -sgmd_pkg::PiQ30;
    m = zr[sgmd_pkg::ZW-1] ? -zr : zr;
    r = ($unsigned(m) + (sgmd_pkg::ZW)'(1 << (29 - sgmd_pkg::AngleFracBits)))
        >> (30 - sgmd_pkg::AngleFracBits);
    rs = zr[sgmd_pkg::ZW-1] ? -$signed(r) : $signed(r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sgmd_pkg::BK_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      sgmd_pkg::BK_IDLE: if (win_valid_i) begin
        gx_q <= gx; gy_q <= gy; last_q <= win_i.last;
      end
      sgmd_pkg::BK_MAG: begin
        mag_q <= 25'($unsigned(32'(gx_q * gx_q))) + 25'($unsigned(32'(gy_q * gy_q)));
        i_q <= '0;
        if (gx_q == 0) z_q <= (gy_q >= 0) ? '0 : sgmd_pkg::PiQ30;
        else if (gy_q == 0) z_q <= (gx_q > 0) ? sgmd_pkg::HalfPiQ30 : -sgmd_pkg::HalfPiQ30;
        else if (gy_q < 0) begin
          x_q <= (sgmd_pkg::CordicW)'(-32'(gy_q)) <<< 16;
          y_q <= (sgmd_pkg::CordicW)'(-32'(gx_q)) <<< 16;
          z_q <= (gx_q > 0) ? sgmd_pkg::PiQ30 : -sgmd_pkg::PiQ30;
        end else begin
          x_q <= 32'(gy_q) <<< 16;
          y_q <= 32'(gx_q) <<< 16;
          z_q <= '0;
        end
      end
      sgmd_pkg::BK_ITER: begin
        if (!y_q[sgmd_pkg::CordicW-1]) begin
          x_q <= x_q + dy; y_q <= y_q - dx;
          z_q <= z_q + sgmd_pkg::atan_q30(32'(i_q));
        end else begin
          x_q <= x_q - dy; y_q <= y_q + dx;
          z_q <= z_q - sgmd_pkg::atan_q30(32'(i_q));
        end
        i_q <= i_q + 5'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (rs > 34'sd16383) dir_sat = 15'sd16383;
    else if (rs < -34'sd16384) dir_sat = -15'sd16384;
    else dir_sat = rs[14:0];
  end

  assign mag_o = mag_q;
  assign dir_o = dir_sat;
  assign gx_o = gx_q;
  assign gy_o = gy_q;
  assign last_o = last_q;
endmodule

/* rtl/core/sgmd_outq.sv */
// Result queue that parts the back end from the consumer.
module sgmd_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [66:0]        in_data_i,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [66:0]        out_data_o
);
  logic [66:0] mem_q [sgmd_pkg::QDepth];
  logic [sgmd_pkg::QPtrW-1:0] wp_q, rp_q;
  logic [sgmd_pkg::QPtrW:0] cnt_q;
  logic wr, rd;
  assign in_ready_o = cnt_q != (sgmd_pkg::QPtrW+1)'(sgmd_pkg::QDepth);
  assign empty_o = cnt_q == '0;
  assign wr = in_valid_i && in_ready_o;
  assign rd = pop_i && !empty_o;
  assign out_data_o = mem_q[rp_q];
  always_ff @(posedge clk_i) if (wr) mem_q[wp_q] <= in_data_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
    end
  end
endmodule

/* rtl/core/scharr_gradient_magnitude_direction.sv */
// The back end computes the squared magnitude and then runs the direction CORDIC, which it
// skips when a gradient is zero.
// The back end works on one result at a time and takes no new window until its result
// enters the queue; the front end accepts no new item until its windows are passed on.
// A full result queue stalls the back end. Reset: asynchronous active low; counters,
// window and queues clear, line stores hold undefined data until written.
module scharr_gradient_magnitude_direction (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic               cmd_i,
  input  logic [7:0]         pixel_i,
  output logic               empty,
  input  logic               pop,
  output logic [24:0]        magnitude_sq_o,
  output logic signed [14:0] direction_o,
  output logic signed [12:0] grad_x_o,
  output logic signed [12:0] grad_y_o,
  output logic               frame_last_o
);
  logic in_ready, win_valid, win_ready, res_valid, res_ready;
  sgmd_pkg::win_t win;
  logic [24:0] mag;
  logic signed [14:0] dir;
  logic signed [12:0] gx, gy;
  logic last;
  logic [66:0] qd;

  assign full = !in_ready;

  sgmd_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(push), .cmd_i, .pixel_i, .in_ready_o(in_ready),
    .win_valid_o(win_valid), .win_o(win), .win_ready_i(win_ready)
  );

  sgmd_back u_back (
    .clk_i, .rst_ni, .win_valid_i(win_valid), .win_i(win), .win_ready_o(win_ready),
    .res_valid_o(res_valid), .res_ready_i(res_ready), .mag_o(mag), .dir_o(dir),
    .gx_o(gx), .gy_o(gy), .last_o(last)
  );

  sgmd_outq u_outq (
    .clk_i, .rst_ni, .in_valid_i(res_valid), .in_ready_o(res_ready),
    .in_data_i({mag, dir, gx, gy, last}), .empty_o(empty), .pop_i(pop),
    .out_data_o(qd)
  );

  assign {magnitude_sq_o, direction_o, grad_x_o, grad_y_o, frame_last_o} = qd;
endmodule

/* rtl/core/sgmd_checker.sv */
// Port-level checker for the Scharr block and its bind statement.
`include "scharr_gradient_magnitude_direction_assert.svh"
module sgmd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic [24:0]        magnitude_sq_o,
  input logic signed [14:0] direction_o,
  input logic signed [12:0] grad_x_o,
  input logic signed [12:0] grad_y_o
);
  `SGMD_ASSERT_IMPL(a_mag, clk_i, rst_ni, empty || magnitude_sq_o == 25'($unsigned(32'(grad_x_o * grad_x_o) + 32'(grad_y_o * grad_y_o))), "magnitude mismatch")
  `SGMD_ASSERT_IMPL(a_dir0, clk_i, rst_ni, empty || !(grad_x_o == 0 && grad_y_o >= 0) || direction_o == 0, "direction not zero")
  `SGMD_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(magnitude_sq_o), "result changed while stalled")
endmodule

bind scharr_gradient_magnitude_direction sgmd_checker u_sgmd_checker (
  .clk_i, .rst_ni, .empty, .pop, .magnitude_sq_o, .direction_o, .grad_x_o, .grad_y_o
);
